// ----- rtl/scep_pkg.sv -----
package scep_pkg;

    localparam int STORE_ID_BYTES     = 16;
    localparam int NAMESPACE_BYTES    = 16;
    localparam int LINEAGE_BYTES      = 16;
    localparam int DIGEST_BYTES       = 32;
    localparam int KEY_ID_MAX_BYTES   = 32;
    localparam int MAX_ENVELOPE_BYTES = 1024;
    localparam int SCHEMA_LEN         = 35;

    localparam logic [7:0] NULL_BYTE = 8'hf6;
    localparam logic [7:0] CHAR_MAX  = 8'h7f;

    typedef enum logic [2:0] {
        EL_MAP, EL_EQ, EL_NUM, EL_BYTES, EL_TEXT, EL_NULL
    } el_kind_t;

    typedef enum logic [1:0] {
        ST_BUSY   = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_REJECT = 2'd2
    } status_t;

    typedef struct packed {
        el_kind_t    kind;
        logic [3:0]  field;
        logic [5:0]  arg;
    } schema_el_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  field_code;
        logic [7:0]  byte_value;
        logic [5:0]  field_offset;
        logic [63:0] number_value;
        logic        number_ready;
        logic [1:0]  parse_status;
    } out_word_t;

    function automatic schema_el_t schema_el(input logic [5:0] step);
        schema_el_t e;
        e = '{EL_EQ, 4'd0, 6'd0};
        case (step)
            6'd0:  e = '{EL_MAP, 4'd0, 6'd2};
            6'd1:  e = '{EL_EQ, 4'd0, 6'd0};
            6'd2:  e = '{EL_MAP, 4'd0, 6'd4};
            6'd3:  e = '{EL_EQ, 4'd0, 6'd0};
            6'd4:  e = '{EL_MAP, 4'd0, 6'd11};
            6'd5:  e = '{EL_EQ, 4'd0, 6'd0};
            6'd6:  e = '{EL_EQ, 4'd0, 6'd1};
            6'd7:  e = '{EL_EQ, 4'd0, 6'd1};
            6'd8:  e = '{EL_EQ, 4'd0, 6'd0};
            6'd9:  e = '{EL_EQ, 4'd0, 6'd2};
            6'd10: e = '{EL_BYTES, 4'd1, 6'(STORE_ID_BYTES)};
            6'd11: e = '{EL_EQ, 4'd0, 6'd3};
            6'd12: e = '{EL_BYTES, 4'd2, 6'(NAMESPACE_BYTES)};
            6'd13: e = '{EL_EQ, 4'd0, 6'd4};
            6'd14: e = '{EL_NUM, 4'd7, 6'd0};
            6'd15: e = '{EL_EQ, 4'd0, 6'd5};
            6'd16: e = '{EL_BYTES, 4'd3, 6'(LINEAGE_BYTES)};
            6'd17: e = '{EL_EQ, 4'd0, 6'd6};
            6'd18: e = '{EL_NUM, 4'd8, 6'd0};
            6'd19: e = '{EL_EQ, 4'd0, 6'd7};
            6'd20: e = '{EL_NUM, 4'd9, 6'd0};
            6'd21: e = '{EL_EQ, 4'd0, 6'd8};
            6'd22: e = '{EL_NUM, 4'd10, 6'd0};
            6'd23: e = '{EL_EQ, 4'd0, 6'd9};
            6'd24: e = '{EL_BYTES, 4'd4, 6'(DIGEST_BYTES)};
            6'd25: e = '{EL_EQ, 4'd0, 6'd10};
            6'd26: e = '{EL_NULL, 4'd0, 6'd0};
            6'd27: e = '{EL_EQ, 4'd0, 6'd1};
            6'd28: e = '{EL_TEXT, 4'd5, 6'd0};
            6'd29: e = '{EL_EQ, 4'd0, 6'd2};
            6'd30: e = '{EL_EQ, 4'd0, 6'd1};
            6'd31: e = '{EL_EQ, 4'd0, 6'd3};
            6'd32: e = '{EL_NUM, 4'd11, 6'd0};
            6'd33: e = '{EL_EQ, 4'd0, 6'd1};
            6'd34: e = '{EL_BYTES, 4'd6, 6'(DIGEST_BYTES)};
            default: e = '{EL_EQ, 4'd0, 6'd0};
        endcase
        return e;
    endfunction

endpackage

// ----- rtl/scep_core.sv -----
module scep_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  scep_pkg::in_word_t in_word,
    output scep_pkg::out_word_t res_word
);
    import scep_pkg::*;

    logic [5:0]  step_reg, step_next;
    logic [3:0]  hleft_reg, hleft_next;
    logic [1:0]  wcode_reg, wcode_next;
    logic [63:0] acc_reg, acc_next;
    logic [5:0]  pleft_reg, pleft_next;
    logic [5:0]  poff_reg, poff_next;
    logic [10:0] count_reg, count_next;
    logic        rej_reg, rej_next;
    logic        done_reg, done_next;

    schema_el_t  e;
    logic [7:0]  b;
    logic [4:0]  add;
    logic [63:0] hv, acc_sh;
    logic        ext, fin, bad;
    logic [63:0] minimum;
    logic        adv;
    out_word_t   r;

    assign e      = schema_el(step_reg);
    assign b      = in_word.data_byte;
    assign add    = b[4:0];
    assign acc_sh = {acc_reg[55:0], b};

    always_comb begin
        case (wcode_reg)
            2'd0:    minimum = 64'd24;
            2'd1:    minimum = 64'h100;
            2'd2:    minimum = 64'h10000;
            default: minimum = 64'h1_0000_0000;
        endcase
    end

    always_comb begin
        logic [2:0] want;
        step_next  = step_reg;
        hleft_next = hleft_reg;
        wcode_next = wcode_reg;
        acc_next   = acc_reg;
        pleft_next = pleft_reg;
        poff_next  = poff_reg;
        count_next = count_reg;
        rej_next   = rej_reg;
        done_next  = done_reg;
        r          = '0;
        bad        = 1'b0;
        adv        = 1'b0;
        fin        = 1'b0;
        ext        = 1'b0;
        hv         = '0;
        want       = 3'd0;
        if (rej_reg || done_reg || count_reg >= 11'(MAX_ENVELOPE_BYTES)
            || step_reg >= 6'(SCHEMA_LEN)) begin
            bad = 1'b1;
        end else begin
            count_next = count_reg + 11'd1;
            if (pleft_reg != 6'd0) begin
                if (e.kind == EL_TEXT && (b == 8'd0 || b > CHAR_MAX)) begin
                    bad = 1'b1;
                end else begin
                    r.field_code   = e.field;
                    r.byte_value   = b;
                    r.field_offset = poff_reg;
                    poff_next      = poff_reg + 6'd1;
                    pleft_next     = pleft_reg - 6'd1;
                    adv            = (pleft_reg == 6'd1);
                end
            end else if (hleft_reg != 4'd0) begin
                if (e.kind == EL_NUM) r.field_code = e.field;
                acc_next   = acc_sh;
                hleft_next = hleft_reg - 4'd1;
                if (hleft_reg == 4'd1) begin
                    fin = 1'b1;
                    ext = 1'b1;
                    hv  = acc_sh;
                end
            end else if (e.kind == EL_NULL) begin
                if (b == NULL_BYTE) adv = 1'b1;
                else bad = 1'b1;
            end else begin
                case (e.kind)
                    EL_MAP:   want = 3'd5;
                    EL_BYTES: want = 3'd2;
                    EL_TEXT:  want = 3'd3;
                    default:  want = 3'd0;
                endcase
                if (e.kind == EL_NUM) r.field_code = e.field;
                if (b[7:5] != want || add > 5'd27) begin
                    bad = 1'b1;
                end else if (add < 5'd24) begin
                    fin = 1'b1;
                    hv  = {59'd0, add};
                end else begin
                    wcode_next = add[1:0];
                    hleft_next = 4'd1 << add[1:0];
                    acc_next   = '0;
                end
            end
            if (fin) begin
                if (ext && hv < minimum) begin
                    bad = 1'b1;
                end else begin
                    case (e.kind)
                        EL_MAP, EL_EQ: begin
                            if (hv != {58'd0, e.arg}) bad = 1'b1;
                            else adv = 1'b1;
                        end
                        EL_NUM: begin
                            r.number_value = hv;
                            r.number_ready = 1'b1;
                            adv            = 1'b1;
                        end
                        EL_BYTES: begin
                            if (hv != {58'd0, e.arg}) bad = 1'b1;
                            else begin
                                pleft_next = hv[5:0];
                                poff_next  = '0;
                            end
                        end
                        EL_TEXT: begin
                            if (hv < 64'd1 || hv > 64'(KEY_ID_MAX_BYTES)) bad = 1'b1;
                            else begin
                                pleft_next = hv[5:0];
                                poff_next  = '0;
                            end
                        end
                        default: bad = 1'b1;
                    endcase
                end
            end
            if (adv) begin
                step_next = step_reg + 6'd1;
                if (step_reg + 6'd1 >= 6'(SCHEMA_LEN)) done_next = 1'b1;
            end
        end
        if (!bad && in_word.last_byte) begin
            if (done_next) r.parse_status = ST_ACCEPT;
            else bad = 1'b1;
        end
        if (bad) begin
            rej_next       = 1'b1;
            r              = '0;
            r.parse_status = ST_REJECT;
        end
        if (in_word.last_byte) begin
            step_next  = '0;
            hleft_next = '0;
            wcode_next = '0;
            acc_next   = '0;
            pleft_next = '0;
            poff_next  = '0;
            count_next = '0;
            rej_next   = 1'b0;
            done_next  = 1'b0;
        end
    end

    assign res_word = r;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            hleft_reg <= '0;
            wcode_reg <= '0;
            acc_reg   <= '0;
            pleft_reg <= '0;
            poff_reg  <= '0;
            count_reg <= '0;
            rej_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end else if (step_en) begin
            step_reg  <= step_next;
            hleft_reg <= hleft_next;
            wcode_reg <= wcode_next;
            acc_reg   <= acc_next;
            pleft_reg <= pleft_next;
            poff_reg  <= poff_next;
            count_reg <= count_next;
            rej_reg   <= rej_next;
            done_reg  <= done_next;
        end
    end

    // payload and head count never both active
    a_head_pay: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pleft_reg != 6'd0 && hleft_reg != 4'd0))
        else $error("head and payload both pending");
    // done only at end of schema
    a_done_step: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> step_reg == 6'(SCHEMA_LEN))
        else $error("done flag without full schema");
    // a number result only when not rejected
    a_ready_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        r.number_ready |-> r.parse_status != ST_REJECT)
        else $error("number on rejected word");

endmodule

// ----- rtl/strict_cbor_envelope_parser.sv -----
// strict cbor envelope parser
// s_ channel: one envelope byte per word, s_data.last_byte marks the final
//   byte of an envelope; m_ channel: one result word per input word
// each accepted byte is checked against the fixed schema in combinational
//   logic and the result lands in the output register, so m_valid rises
//   in the cycle after acceptance
// throughput, barring stalls, is one word per cycle: the schema state
//   updates on the accepting edge, so the next byte follows straight away
// the output register is refilled on the same edge it is drained, so a
//   word can be taken every cycle while the receiver keeps up
// when the receiver stalls, m_data holds and s_ready drops until the
//   waiting word is taken
// parse_status reports progress, acceptance on the last byte, or rejection;
//   after a rejection every byte up to the last one is reported rejected
// reset clears the schema position, counters and flags and empties the
//   output register; a new envelope begins after any last byte
module strict_cbor_envelope_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  scep_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output scep_pkg::out_word_t m_data
);
    import scep_pkg::*;

    logic      take;
    out_word_t res;
    out_word_t data_reg;
    logic      valid_reg;

    // free when empty or draining this cycle
    assign s_ready = !valid_reg || m_ready;
    assign take    = s_valid && s_ready;

    scep_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (take),
        .in_word  (s_data),
        .res_word (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge aclk) begin
        if (take) begin
            data_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled word changed");
    a_no_take_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("accepted into full register");
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> m_valid)
        else $error("accepted word not presented");

endmodule
